/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/grq_pkg.sv */
// Types and constants for the gossip retransmit queue.
package grq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int PER_PACKET_DEF  = 4;

  localparam int NODE_W = 8;
  localparam int CODE_W = 8;
  localparam int LEFT_W = 4;
  localparam int ENTRY_W = NODE_W + CODE_W + LEFT_W;

  localparam logic [LEFT_W-1:0] SEND_COUNT_RESET = 4'd6;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_FILL = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [CODE_W-1:0] code;
    logic [LEFT_W-1:0] left;
  } entry_t;

  typedef struct packed {
    logic              match;
    logic              less;
    logic              emit;
    logic              keep;
    logic [LEFT_W-1:0] left_new;
  } scan_res_t;

endpackage

/* hdl/grq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module grq_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/grq_scan_unit.sv */
// Per-entry compare and decrement unit, reused for every slot of a scan.
module grq_scan_unit import grq_pkg::*; #(
  parameter int PER_PACKET = PER_PACKET_DEF
) (
  input  entry_t                            entry,
  input  logic [NODE_W-1:0]                 node,
  input  logic [$clog2(PER_PACKET+1)-1:0]   sent,
  input  logic [LEFT_W-1:0]                 min_left,
  input  logic                              first,
  output scan_res_t                         res
);

  localparam int SW = $clog2(PER_PACKET + 1);

  always_comb begin
    res.match    = (entry.node == node);
    res.less     = first || (entry.left < min_left);
    res.emit     = (entry.left != '0) && (sent < SW'(PER_PACKET));
    res.left_new = res.emit ? entry.left - LEFT_W'(1) : entry.left;
    res.keep     = (res.left_new != '0);
  end

endmodule

/* hdl/gossip_retransmit_queue_unit.sv */
// Gossip retransmit queue: sequencer over one queue RAM and a shared scan unit.
// Each request passes through the START state, a slot-by-slot SCAN of the occupied
// slots and the FIN state; an empty queue skips the scan. No new request is taken until
// the previous one is finished. The scan goes through the single RAM read port, and
// output stalls hold a fill in SCAN and FIN.
// Reset: synchronous; empties the queue and loads send_count with 6.
module gossip_retransmit_queue_unit import grq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PER_PACKET  = PER_PACKET_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEFT_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [NODE_W-1:0] node_id,
  input  logic [CODE_W-1:0] item_state,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] out_node_id,
  output logic [CODE_W-1:0] out_state,
  output logic              entry_valid,
  output logic              last
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(PER_PACKET + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]        state, state_next;
  logic [AW-1:0]     idx;
  logic [CW-1:0]     wr_ptr;
  logic [CW-1:0]     occ;
  logic [SW-1:0]     sent;
  logic              found;
  logic [AW-1:0]     fidx;
  logic [AW-1:0]     victim;
  logic [LEFT_W-1:0] min_left;
  logic              cur_mode;
  logic [NODE_W-1:0] cur_node;
  logic [CODE_W-1:0] cur_code;
  logic [LEFT_W-1:0] send_count;
  logic              pend_valid;
  logic [NODE_W-1:0] pend_node;
  logic [CODE_W-1:0] pend_code;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  entry_t               ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               rd_entry;
  scan_res_t            sres;
  logic                 out_free;
  logic                 out_load;
  logic                 proceed;
  logic                 last_idx;
  logic                 in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign rd_entry  = entry_t'(ram_rdata);
  assign out_free  = !out_valid || !out_stall;
  assign last_idx  = (CW'(idx) == occ - CW'(1));

  grq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  grq_scan_unit #(
    .PER_PACKET (PER_PACKET)
  ) u_scan (
    .entry    (rd_entry),
    .node     (cur_node),
    .sent     (sent),
    .min_left (min_left),
    .first    (idx == '0),
    .res      (sres)
  );

  // Hold the scan when a second emission would overrun a busy output register.
  assign proceed = (state == ST_SCAN) &&
                   ((cur_mode == MODE_ADD) || !(sres.emit && pend_valid) || out_free);

  assign out_load = (proceed && (cur_mode == MODE_FILL) && sres.emit && pend_valid) ||
                    ((state == ST_FIN) && (cur_mode == MODE_FILL) && out_free);

  always_comb begin
    ram_raddr = '0;
    if (state == ST_SCAN) begin
      ram_raddr = proceed ? idx + AW'(1) : idx;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr[AW-1:0];
    ram_wdata = '{node: rd_entry.node, code: rd_entry.code, left: sres.left_new};
    if (state == ST_SCAN) begin
      ram_we = proceed && (cur_mode == MODE_FILL) && sres.keep;
    end else if (state == ST_FIN && cur_mode == MODE_ADD) begin
      ram_we    = 1'b1;
      ram_wdata = '{node: cur_node, code: cur_code, left: send_count};
      priority if (found) begin
        ram_waddr = fidx;
      end else if (occ < CW'(QUEUE_DEPTH)) begin
        ram_waddr = occ[AW-1:0];
      end else begin
        ram_waddr = victim;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) state_next = ST_START;
      end
      ST_START: begin
        state_next = (occ == '0) ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        if (proceed && last_idx) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (cur_mode == MODE_ADD || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      occ        <= '0;
      send_count <= SEND_COUNT_RESET;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        send_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (in_take) begin
        cur_mode   <= mode;
        cur_node   <= node_id;
        cur_code   <= item_state;
        idx        <= '0;
        wr_ptr     <= '0;
        sent       <= '0;
        found      <= 1'b0;
        pend_valid <= 1'b0;
      end

      if (proceed) begin
        idx <= idx + AW'(1);
        if (cur_mode == MODE_ADD) begin
          if (sres.match && !found) begin
            found <= 1'b1;
            fidx  <= idx;
          end
          if (sres.less) begin
            min_left <= rd_entry.left;
            victim   <= idx;
          end
        end else begin
          if (sres.keep) wr_ptr <= wr_ptr + CW'(1);
          if (sres.emit) begin
            // Push the previous emission out; it is not the final one.
            if (pend_valid) begin
              out_node_id <= pend_node;
              out_state   <= pend_code;
              entry_valid <= 1'b1;
              last        <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_node  <= rd_entry.node;
            pend_code  <= rd_entry.code;
            sent       <= sent + SW'(1);
          end
        end
      end

      if (state == ST_FIN) begin
        if (cur_mode == MODE_ADD) begin
          if (!found && occ < CW'(QUEUE_DEPTH)) occ <= occ + CW'(1);
        end else if (out_free) begin
          out_node_id <= pend_valid ? pend_node : '0;
          out_state   <= pend_valid ? pend_code : '0;
          entry_valid <= pend_valid;
          last        <= 1'b1;
          pend_valid  <= 1'b0;
          occ         <= wr_ptr;
        end
      end
    end
  end

endmodule

/* hdl/grq_checker.sv */
// Port-level checks for the gossip retransmit queue, bound to the top level.
`include "assert_macros.svh"

module grq_checker import grq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [NODE_W-1:0] out_node_id,
  input logic [CODE_W-1:0] out_state,
  input logic              entry_valid,
  input logic              last
);

  `ASSERT_NXT(a_busy_after_request, clk, rst, in_valid && !in_stall, in_stall, "not busy after request")

  `ASSERT_IMP(a_empty_is_last, clk, rst, out_valid && !entry_valid, last, "empty fill result without last")

  `ASSERT_IMP(a_empty_is_zero, clk, rst, out_valid && !entry_valid, out_node_id == '0 && out_state == '0, "empty fill result carries data")

  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_node_id) && $stable(out_state) && $stable(entry_valid) && $stable(last), "stalled result changed")

endmodule

bind gossip_retransmit_queue_unit grq_checker u_grq_checker (.*);

/* tb/testbench.sv */
// Self-checking bench for the gossip retransmit queue unit: random and directed requests.
module testbench;
  import grq_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int PKT         = PER_PACKET_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = QUEUE_DEPTH_DEF + 8;

  typedef struct {
    logic              mode;
    logic [NODE_W-1:0] node;
    logic [CODE_W-1:0] code;
  } gossip_event_t;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic [CODE_W-1:0] code;
    logic              present;
    logic              is_last;
  } gossip_entry_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEFT_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              mode = MODE_ADD;
  logic [NODE_W-1:0] node_id = '0;
  logic [CODE_W-1:0] item_state = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NODE_W-1:0] out_node_id;
  logic [CODE_W-1:0] out_state;
  logic              entry_valid;
  logic              last;

  // Shadow of the retransmit queue and its send count.
  logic [NODE_W-1:0] slot_node [DEPTH];
  logic [CODE_W-1:0] slot_code [DEPTH];
  logic [LEFT_W-1:0] slot_left [DEPTH];
  int                slot_count = 0;
  logic [LEFT_W-1:0] send_count_model = SEND_COUNT_RESET;

  gossip_event_t event_feed [$];
  gossip_entry_t expected_gossip [$];
  gossip_event_t on_bus;
  gossip_entry_t want;

  int unsigned idle_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int          mismatches = 0;
  bit          calm = 1'b0;

  gossip_retransmit_queue_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .node_id    (node_id),
    .item_state (item_state),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_node_id(out_node_id),
    .out_state  (out_state),
    .entry_valid(entry_valid),
    .last       (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one accepted request to the shadow queue and queue up the entries it sends.
  task automatic advance_gossip_queue(input gossip_event_t ev);
    int victim;
    int to_send;
    int sent;
    int w;
    bit hit;
    gossip_entry_t r;
    hit = 1'b0;
    if (ev.mode == MODE_ADD) begin
      for (int i = 0; i < slot_count; i++) begin
        if (!hit && slot_node[i] == ev.node) begin
          slot_code[i] = ev.code;
          slot_left[i] = send_count_model;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        victim = slot_count;
        if (slot_count < DEPTH) begin
          slot_count++;
        end else begin
          // full: evict the lowest count, first one wins a tie
          victim = 0;
          for (int i = 1; i < DEPTH; i++)
            if (slot_left[i] < slot_left[victim]) victim = i;
        end
        slot_node[victim] = ev.node;
        slot_code[victim] = ev.code;
        slot_left[victim] = send_count_model;
      end
    end else begin
      to_send = 0;
      for (int i = 0; i < slot_count; i++)
        if (slot_left[i] != 0 && to_send < PKT) to_send++;
      sent = 0;
      for (int i = 0; i < slot_count; i++) begin
        if (slot_left[i] != 0 && sent < to_send) begin
          r.node    = slot_node[i];
          r.code    = slot_code[i];
          r.present = 1'b1;
          r.is_last = (sent == to_send - 1);
          expected_gossip.push_back(r);
          sent++;
          slot_left[i] = slot_left[i] - 1'b1;
        end
      end
      // drop retired entries, keep order
      w = 0;
      for (int i = 0; i < slot_count; i++) begin
        if (slot_left[i] != 0) begin
          slot_node[w] = slot_node[i];
          slot_code[w] = slot_code[i];
          slot_left[w] = slot_left[i];
          w++;
        end
      end
      slot_count = w;
      if (to_send == 0) begin
        r.node    = '0;
        r.code    = '0;
        r.present = 1'b0;
        r.is_last = 1'b1;
        expected_gossip.push_back(r);
      end
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_gap = 0;
    end else begin
      if (in_valid && !in_stall) advance_gossip_queue(on_bus);
      if (!in_valid || !in_stall) begin
        if (idle_gap == 0 && !calm && $urandom_range(0, 7) == 0)
          idle_gap = $urandom_range(1, 14);
        if (idle_gap > 0) begin
          idle_gap--;
          in_valid <= 1'b0;
        end else if (event_feed.size() != 0) begin
          on_bus = event_feed.pop_front();
          in_valid   <= 1'b1;
          mode       <= on_bus.mode;
          node_id    <= on_bus.node;
          item_state <= on_bus.code;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_gossip.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected entry: node %02h state %02h valid %0b last %0b",
                     out_node_id, out_state, entry_valid, last);
          mismatches++;
        end else begin
          want = expected_gossip.pop_front();
          if (out_node_id !== want.node || out_state !== want.code ||
              entry_valid !== want.present || last !== want.is_last) begin
            if (mismatches < 10)
              $display({"entry mismatch: expected node %02h state %02h valid %0b last %0b,",
                        " got node %02h state %02h valid %0b last %0b"},
                       want.node, want.code, want.present, want.is_last,
                       out_node_id, out_state, entry_valid, last);
            mismatches++;
          end
        end
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic post_event(input logic m, input logic [NODE_W-1:0] n,
                            input logic [CODE_W-1:0] c);
    gossip_event_t ev;
    ev.mode = m;
    ev.node = n;
    ev.code = c;
    event_feed.push_back(ev);
  endtask

  // Mostly a small pool of nodes so refreshes and evictions happen.
  task automatic post_random_events(input int count);
    logic [NODE_W-1:0] pool [12];
    logic [NODE_W-1:0] nid;
    logic [CODE_W-1:0] code;
    foreach (pool[i]) pool[i] = NODE_W'($urandom_range(0, 255));
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) nid = NODE_W'($urandom_range(0, 255));
      else nid = pool[$urandom_range(0, 11)];
      code = CODE_W'($urandom_range(0, 255));
      post_event(($urandom_range(0, 99) < 35) ? MODE_FILL : MODE_ADD, nid, code);
    end
  endtask

  // Hold until every request is in and every entry is out, then let the scan finish.
  task automatic drain();
    while (event_feed.size() != 0 || in_valid || expected_gossip.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_send_count(input logic [LEFT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    send_count_model = v;
    @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty fill, field extremes, refresh, full queue, eviction.
    post_event(MODE_FILL, 8'h00, 8'h00);
    post_event(MODE_ADD, 8'h00, 8'h00);
    post_event(MODE_ADD, 8'hFF, 8'hFF);
    post_event(MODE_ADD, 8'h00, 8'hA5);
    post_event(MODE_FILL, 8'hFF, 8'hFF);
    post_event(MODE_ADD, 8'h11, 8'h01);
    post_event(MODE_ADD, 8'h22, 8'h80);
    post_event(MODE_ADD, 8'h44, 8'h5A);
    post_event(MODE_ADD, 8'h88, 8'hC3);
    post_event(MODE_ADD, 8'h5A, 8'h3C);
    post_event(MODE_ADD, 8'hC3, 8'h7E);
    post_event(MODE_FILL, 8'h00, 8'h00);
    post_event(MODE_ADD, 8'h77, 8'h99);
    post_event(MODE_FILL, 8'h00, 8'h00);
    post_event(MODE_FILL, 8'h00, 8'h00);
    drain();

    // Zero send count: stored, never sent, still matches, dropped on next fill.
    set_send_count('0);
    post_event(MODE_ADD, 8'h33, 8'h0F);
    post_event(MODE_ADD, 8'h33, 8'hF0);
    post_event(MODE_ADD, 8'h66, 8'h99);
    post_event(MODE_FILL, 8'h00, 8'h00);
    post_event(MODE_FILL, 8'h00, 8'h00);
    drain();

    set_send_count(4'd15);
    post_random_events(22);
    drain();
    set_send_count(4'd1);
    post_random_events(22);
    drain();
    set_send_count(LEFT_W'($urandom_range(2, 14)));
    post_random_events(22);
    drain();
    calm = 1'b1;
    set_send_count(SEND_COUNT_RESET);
    post_random_events(22);
    drain();

    if (mismatches == 0 && expected_gossip.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/grq_pkg.sv
hdl/grq_ram.sv
hdl/grq_scan_unit.sv
hdl/gossip_retransmit_queue_unit.sv
hdl/grq_checker.sv
tb/testbench.sv
